>>> hdl/assert_macros.svh
// Assertion macros shared by the list RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset
`define ILID_ASSERT(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("list assertion failed");

// Check a condition in the cycle after a trigger
`define ILID_ASSERT_NEXT(lbl, clk, rst_n, trig, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("list assertion failed");

`endif

>>> hdl/ilid_pkg.sv
// Types and constants for the indexed list
package ilid_pkg;

    localparam int POS_W       = 5;
    localparam int IN_WORD_W   = 32;
    localparam int OUT_WORD_W  = 32;
    localparam int CNT_OUT_W   = 5;
    localparam int KIND_W      = 2;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 40;

    localparam logic [KIND_W-1:0] KIND_APPEND = 2'd0;
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DELETE = 2'd2;
    localparam logic [KIND_W-1:0] KIND_READ   = 2'd3;

    typedef struct packed {
        logic                  ok;
        logic [OUT_WORD_W-1:0] word;
        logic [CNT_OUT_W-1:0]  count;
    } res_t;

endpackage

>>> hdl/ilid_ram.sv
// Entry store: one write port, one registered read port
module ilid_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/ilid_ctrl.sv
// Request sequencer: bounds checks, entry shifting through the store, count
module ilid_ctrl import ilid_pkg::*; #(
    parameter int CAPACITY   = 16,
    parameter int WORD_WIDTH = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [KIND_W-1:0]           kind,
    input  logic [POS_W-1:0]            position,
    input  logic [IN_WORD_W-1:0]        word_in,
    output logic                        res_valid,
    input  logic                        res_ready,
    output res_t                        res,
    output logic                        mem_we,
    output logic [$clog2(CAPACITY)-1:0] mem_waddr,
    output logic [WORD_WIDTH-1:0]       mem_wdata,
    output logic                        mem_re,
    output logic [$clog2(CAPACITY)-1:0] mem_raddr,
    input  logic [WORD_WIDTH-1:0]       mem_rdata
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > POS_W) ? CW : POS_W;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SHUP = 3'd1;
    localparam logic [2:0] ST_INS  = 3'd2;
    localparam logic [2:0] ST_DEL  = 3'd3;
    localparam logic [2:0] ST_SHDN = 3'd4;
    localparam logic [2:0] ST_RD   = 3'd5;
    localparam logic [2:0] ST_RES  = 3'd6;

    logic [2:0]            state_reg, state_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [AW-1:0]         idx_reg, idx_next;
    logic [AW-1:0]         pos_reg, pos_next;
    logic [WORD_WIDTH-1:0] hold_reg, hold_next;
    logic                  ok_reg, ok_next;
    logic [OUT_WORD_W-1:0] word_reg, word_next;

    logic [PW-1:0] pos_ext;
    logic [PW-1:0] cnt_ext;
    logic          full;
    logic [CW-1:0] idx_inc;

    assign pos_ext = PW'(position);
    assign cnt_ext = PW'(count_reg);
    assign full    = (count_reg == CW'(CAPACITY));
    assign idx_inc = CW'(idx_reg) + CW'(1);

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        pos_next   = pos_reg;
        hold_next  = hold_reg;
        ok_next    = ok_reg;
        word_next  = word_reg;
        mem_we     = 1'b0;
        mem_waddr  = '0;
        mem_wdata  = '0;
        mem_re     = 1'b0;
        mem_raddr  = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    ok_next    = 1'b0;
                    word_next  = '0;
                    state_next = ST_RES;
                    unique case (kind)
                        KIND_APPEND:
                        begin
                            if (!full)
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = AW'(count_reg);
                                mem_wdata  = WORD_WIDTH'(word_in);
                                count_next = count_reg + CW'(1);
                                ok_next    = 1'b1;
                            end
                        end
                        KIND_INSERT:
                        begin
                            if (!full && pos_ext == cnt_ext)
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = AW'(count_reg);
                                mem_wdata  = WORD_WIDTH'(word_in);
                                count_next = count_reg + CW'(1);
                                ok_next    = 1'b1;
                            end
                            else if (!full && pos_ext < cnt_ext)
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = AW'(count_reg - CW'(1));
                                idx_next   = AW'(count_reg - CW'(1));
                                pos_next   = AW'(position);
                                hold_next  = WORD_WIDTH'(word_in);
                                state_next = ST_SHUP;
                            end
                        end
                        KIND_DELETE:
                        begin
                            if (pos_ext < cnt_ext)
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = AW'(position);
                                idx_next   = AW'(position);
                                state_next = ST_DEL;
                            end
                        end
                        KIND_READ:
                        begin
                            if (pos_ext < cnt_ext)
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = AW'(position);
                                state_next = ST_RD;
                            end
                        end
                        default:
                        begin
                            state_next = ST_RES;
                        end
                    endcase
                end
            end
            ST_SHUP:
            begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg + AW'(1);
                mem_wdata = mem_rdata;
                if (idx_reg == pos_reg)
                begin
                    state_next = ST_INS;
                end
                else
                begin
                    mem_re    = 1'b1;
                    mem_raddr = idx_reg - AW'(1);
                    idx_next  = idx_reg - AW'(1);
                end
            end
            ST_INS:
            begin
                mem_we     = 1'b1;
                mem_waddr  = pos_reg;
                mem_wdata  = hold_reg;
                count_next = count_reg + CW'(1);
                ok_next    = 1'b1;
                state_next = ST_RES;
            end
            ST_DEL:
            begin
                word_next = OUT_WORD_W'(mem_rdata);
                ok_next   = 1'b1;
                if (idx_inc < count_reg)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = AW'(idx_inc);
                    idx_next   = AW'(idx_inc);
                    state_next = ST_SHDN;
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                    state_next = ST_RES;
                end
            end
            ST_SHDN:
            begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg - AW'(1);
                mem_wdata = mem_rdata;
                if (idx_inc < count_reg)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = AW'(idx_inc);
                    idx_next  = AW'(idx_inc);
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                    state_next = ST_RES;
                end
            end
            ST_RD:
            begin
                word_next  = OUT_WORD_W'(mem_rdata);
                ok_next    = 1'b1;
                state_next = ST_RES;
            end
            ST_RES:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        pos_reg  <= pos_next;
        hold_reg <= hold_next;
        ok_reg   <= ok_next;
        word_reg <= word_next;
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_RES);
    assign res       = '{ok: ok_reg, word: word_reg, count: CNT_OUT_W'(count_reg)};

endmodule

>>> hdl/indexed_list_insert_delete.sv
// Indexed list top level: stream ports, sequencer, entry store and output register
// Input beat to output beat: the sequencer takes the request, then the result passes the
// output register; reads, deletes and inserts below the end first go through the store's
// registered read port (one entry moved per cycle through the store).
// Throughput: one request at a time; the next input beat is taken no earlier than the edge
// of the first possible output beat, and a stalled output holds the sequencer.
`include "assert_macros.svh"

module indexed_list_insert_delete import ilid_pkg::*; #(
    parameter int CAPACITY   = 16,
    parameter int WORD_WIDTH = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // position[4:0], word_in[36:5], zero pad
    input  logic [KIND_W-1:0]      s_tuser,   // kind[1:0]
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // word_out[31:0], count_out[36:32], zero pad
    output logic                   m_tuser    // ok
);

    localparam int AW = $clog2(CAPACITY);

    logic                  res_valid;
    logic                  res_ready;
    res_t                  res;
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [WORD_WIDTH-1:0] mem_wdata;
    logic                  mem_re;
    logic [AW-1:0]         mem_raddr;
    logic [WORD_WIDTH-1:0] mem_rdata;

    logic out_valid_reg, out_valid_next;
    res_t out_res_reg, out_res_next;

    ilid_ctrl #(
        .CAPACITY   (CAPACITY),
        .WORD_WIDTH (WORD_WIDTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .kind      (s_tuser),
        .position  (s_tdata[POS_W-1:0]),
        .word_in   (s_tdata[POS_W +: IN_WORD_W]),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    ilid_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (WORD_WIDTH)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign res_ready = !out_valid_reg || m_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
            out_res_next   = res;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_TDATA_W'({out_res_reg.count, out_res_reg.word});
    assign m_tuser  = out_res_reg.ok;

    `ILID_ASSERT(a_busy_excl, clk, rst_n, !(s_tready && res_valid))
    `ILID_ASSERT(a_refused_zero, clk, rst_n, !res_valid || res.ok || (res.word == '0))
    `ILID_ASSERT_NEXT(a_out_load, clk, rst_n, res_valid && res_ready, m_tvalid && !res_valid)

endmodule

>>> dv/tb_indexed_list_insert_delete.sv
// Stream testbench for the indexed list: directed and random requests checked against a list model
module tb_indexed_list_insert_delete;
    import ilid_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIST_DEPTH  = 16;
    localparam int HOLD_CYCLES = 300;
    localparam int QUIET_LIMIT = 5000;
    localparam int SETTLE      = 40;

    typedef struct {
        logic [KIND_W-1:0]    kind;
        logic [POS_W-1:0]     pos;
        logic [IN_WORD_W-1:0] word;
    } list_req_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;   // position[4:0], word_in[36:5], zero pad
    logic [KIND_W-1:0]      s_tuser = '0;   // kind[1:0]
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;        // word_out[31:0], count_out[36:32], zero pad
    logic                   m_tuser;        // ok

    list_req_t             pending_reqs[$];
    res_t                  expected_results[$];
    logic [IN_WORD_W-1:0]  model_cells[LIST_DEPTH];
    int                    model_count = 0;
    int                    planned_count = 0;
    int                    send_idle_pct = 0;
    int                    recv_stall_pct = 0;
    int                    hold_req = 0;
    int                    hold_ack = 0;
    int                    hold_left = 0;
    int                    mismatches = 0;
    int                    quiet_cycles = 0;
    bit                    in_taken = 1'b0;

    indexed_list_insert_delete uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic res_t list_apply(logic [KIND_W-1:0] kind, logic [POS_W-1:0] pos,
                                        logic [IN_WORD_W-1:0] word);
        res_t r;
        int   i;
        r = '0;
        case (kind)
            KIND_APPEND:
                if (model_count < LIST_DEPTH)
                begin
                    model_cells[model_count] = word;
                    model_count++;
                    r.ok = 1'b1;
                end
            KIND_INSERT:
                if (model_count < LIST_DEPTH && int'(pos) <= model_count)
                begin
                    for (i = model_count; i > int'(pos); i--)
                        model_cells[i] = model_cells[i-1];
                    model_cells[pos] = word;
                    model_count++;
                    r.ok = 1'b1;
                end
            KIND_DELETE:
                if (int'(pos) < model_count)
                begin
                    r.word = model_cells[pos];
                    for (i = int'(pos); i + 1 < model_count; i++)
                        model_cells[i] = model_cells[i+1];
                    model_count--;
                    r.ok = 1'b1;
                end
            default:
                if (int'(pos) < model_count)
                begin
                    r.word = model_cells[pos];
                    r.ok = 1'b1;
                end
        endcase
        r.count = model_count[CNT_OUT_W-1:0];
        return r;
    endfunction

    task automatic push_req(logic [KIND_W-1:0] kind, int pos, logic [IN_WORD_W-1:0] word);
        list_req_t q;
        q.kind = kind;
        q.pos  = pos[POS_W-1:0];
        q.word = word;
        pending_reqs.push_back(q);
        // track the fill level so that later positions land in range
        if ((kind == KIND_APPEND && planned_count < LIST_DEPTH) ||
            (kind == KIND_INSERT && planned_count < LIST_DEPTH && pos <= planned_count))
            planned_count++;
        else if (kind == KIND_DELETE && pos < planned_count)
            planned_count--;
    endtask

    task automatic queue_random(int n, int grow_pct);
        logic [KIND_W-1:0]    kind;
        logic [IN_WORD_W-1:0] word;
        int                   pos;
        repeat (n)
        begin
            if ($urandom_range(99) < grow_pct)
                kind = ($urandom_range(99) < 40) ? KIND_APPEND : KIND_INSERT;
            else
                kind = ($urandom_range(99) < 70) ? KIND_DELETE : KIND_READ;
            case ($urandom_range(9))
                0:       word = '0;
                1:       word = '1;
                default: word = $urandom;
            endcase
            if ($urandom_range(99) < 10)
                pos = $urandom_range(LIST_DEPTH, 0);
            else if (kind == KIND_INSERT)
                pos = $urandom_range(planned_count, 0);
            else if (kind == KIND_APPEND)
                pos = $urandom_range(LIST_DEPTH, 0);
            else
                pos = (planned_count > 0) ? $urandom_range(planned_count - 1, 0) : 0;
            push_req(kind, pos, word);
        end
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || expected_results.size() > 0 || s_tvalid)
            @(posedge clk);
    endtask

    task automatic report_bad(res_t want, res_t got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch at %0t: expected ok=%0b word=%08h count=%0d, got ok=%0b word=%08h count=%0d",
                     $realtime, want.ok, want.word, want.count, got.ok, got.word, got.count);
    endtask

    // driver: advance to the next beat once the current one is taken
    always @(negedge clk)
    begin
        list_req_t q;
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (!s_tvalid || in_taken)
        begin
            if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                q = pending_reqs.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= q.kind;
                s_tdata  <= {{(IN_TDATA_W - POS_W - IN_WORD_W){1'b0}}, q.word, q.pos};
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // receiver: hold off for a long stretch on request, otherwise stall at random
    always @(negedge clk)
    begin
        if (hold_req != hold_ack)
        begin
            hold_ack  = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        res_t got;
        res_t want;
        bit   out_taken;
        in_taken  = rst_n && s_tvalid && s_tready;
        out_taken = rst_n && m_tvalid && m_tready;
        if (in_taken)
            expected_results.push_back(list_apply(s_tuser, s_tdata[POS_W-1:0],
                                                  s_tdata[POS_W +: IN_WORD_W]));
        if (out_taken)
        begin
            got.ok    = m_tuser;
            got.word  = m_tdata[OUT_WORD_W-1:0];
            got.count = m_tdata[OUT_WORD_W +: CNT_OUT_W];
            if (expected_results.size() == 0)
                report_bad('0, got);
            else
            begin
                want = expected_results.pop_front();
                if (got.ok !== want.ok || got.word !== want.word || got.count !== want.count)
                    report_bad(want, got);
            end
        end
        quiet_cycles = (in_taken || out_taken) ? 0 : quiet_cycles + 1;
    end

    always @(posedge clk)
    begin
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        push_req(KIND_READ,   0,  32'h0000_0001);
        push_req(KIND_DELETE, 0,  32'h0000_0002);
        push_req(KIND_INSERT, 1,  32'h0000_0003);
        push_req(KIND_INSERT, 16, 32'h0000_0004);
        push_req(KIND_INSERT, 0,  32'h0000_0000);
        push_req(KIND_APPEND, 16, 32'hFFFF_FFFF);
        push_req(KIND_INSERT, 2,  32'hA5A5_A5A5);
        push_req(KIND_INSERT, 1,  32'h1234_5678);
        push_req(KIND_READ,   0,  32'hFFFF_FFFF);
        push_req(KIND_READ,   1,  32'h0);
        push_req(KIND_READ,   2,  32'h0);
        push_req(KIND_READ,   3,  32'h0);
        push_req(KIND_READ,   4,  32'h0);
        push_req(KIND_DELETE, 1,  32'hFFFF_FFFF);
        push_req(KIND_DELETE, 2,  32'h0);
        push_req(KIND_DELETE, 2,  32'h0);
        push_req(KIND_READ,   16, 32'h0);
        push_req(KIND_DELETE, 0,  32'h0);
        push_req(KIND_READ,   0,  32'h0);
        push_req(KIND_DELETE, 0,  32'h0);
        push_req(KIND_APPEND, 0,  32'h5A5A_5A5A);
        wait_drained();

        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct  = (ph == 1) ? 82 : (ph == 3) ? 28 : 0;
            recv_stall_pct = (ph == 2) ? 82 : (ph == 3) ? 28 : 0;
            if (ph == 0)
                hold_req++;
            for (int chunk = 0; chunk < 6; chunk++)
                queue_random(21, (chunk % 4 < 2) ? 85 : 15);
            wait_drained();
        end

        repeat (SETTLE) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

>>> indexed_list_insert_delete.f
+incdir+hdl
hdl/ilid_pkg.sv
hdl/ilid_ram.sv
hdl/ilid_ctrl.sv
hdl/indexed_list_insert_delete.sv
dv/tb_indexed_list_insert_delete.sv
